/* design/sfid_pkg.sv */
// Shared types, constants and a helper function of the smallest free ID allocator.
package sfid_pkg;

    localparam int ID_W       = 10;   // width of the ID fields on the ports
    localparam int MAX_ID_DEF = 1023;
    localparam int WORD_W     = 32;   // bitmap word width
    localparam int WORD_BW    = 5;    // bit index within a word
    localparam int SPAN_BW    = 10;   // ID bits covered by one summary word

    localparam logic KIND_TAKE = 1'b0;
    localparam logic KIND_GIVE = 1'b1;

    typedef struct packed {
        logic accept;        // input transfer this cycle
        logic tk_sum;        // summary word of a take is on the read port
        logic tk_hold;       // data word of a take is on the read port
        logic tk_commit;     // finish a take from the bitmap
        logic gb_commit;     // finish a give-back
        logic fresh_commit;  // finish a take from the fresh counter
    } sfid_cmd_t;

    typedef struct packed {
        logic gb_ok;         // offered give-back ID is nonzero and below the counter
        logic top_any;       // at least one ID is held in the bitmap
    } sfid_sts_t;

    function automatic logic [WORD_BW-1:0] lowest_set(input logic [WORD_W-1:0] word);
        logic [WORD_BW-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (word[i]) begin
                idx = WORD_BW'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* design/sfid_ctrl.sv */
// Sequencing state machine of the smallest free ID allocator.
module sfid_ctrl
    import sfid_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      s_kind,
    output logic      m_valid,
    input  logic      m_ready,
    input  sfid_sts_t sts,
    output sfid_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GIVE,
        ST_FRESH,
        ST_TK_SUM,
        ST_TK_DATA
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (s_kind == KIND_GIVE) begin
                        state_next = sts.gb_ok ? ST_GIVE : ST_IDLE;
                    end else begin
                        state_next = sts.top_any ? ST_TK_SUM : ST_FRESH;
                    end
                end
            end
            ST_GIVE: begin
                cmd.gb_commit = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_FRESH: begin
                if (out_free) begin
                    cmd.fresh_commit = 1'b1;
                    m_valid_next     = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_TK_SUM: begin
                cmd.tk_sum = 1'b1;
                state_next = ST_TK_DATA;
            end
            ST_TK_DATA: begin
                cmd.tk_hold = 1'b1;
                if (out_free) begin
                    cmd.tk_commit = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* design/sfid_dp.sv */
// Datapath: fresh counter, two-level bitmap memories, summary bits, result register.
module sfid_dp
    import sfid_pkg::*;
#(
    parameter int MAX_ID = MAX_ID_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  sfid_cmd_t       cmd,
    output sfid_sts_t       sts,
    input  logic            s_kind,
    input  logic [ID_W-1:0] s_value,
    output logic [ID_W-1:0] m_id,
    output logic            m_exhausted
);

    localparam int IDW  = ($clog2(MAX_ID + 1) > SPAN_BW) ? $clog2(MAX_ID + 1) : SPAN_BW;
    localparam int NFW  = $clog2(MAX_ID + 2);
    localparam int WIW  = IDW - WORD_BW;
    localparam int NDW  = 2 ** WIW;
    localparam int TW   = IDW - SPAN_BW;
    localparam int NT   = 2 ** TW;
    localparam int TIW  = (TW > 0) ? TW : 1;
    localparam int CMPW = (NFW > ID_W) ? NFW : ID_W;
    localparam logic [NFW-1:0] MAX_NF = NFW'(MAX_ID);

    // memories: data words hold one bit per ID, summary words one bit per data word
    logic [WORD_W-1:0] data_mem [NDW];
    logic [WORD_W-1:0] sum_mem  [NT];

    logic [WORD_W-1:0] data_rdata_reg, sum_rdata_reg;
    logic [WIW-1:0]    data_raddr, data_waddr;
    logic [TIW-1:0]    sum_raddr, sum_waddr;
    logic [WORD_W-1:0] data_wdata, sum_wdata;
    logic              data_we, sum_we;

    logic [NT-1:0]     top_reg, top_next;
    logic [NFW-1:0]    next_fresh_reg;
    logic [IDW-1:0]    value_reg;
    logic [TIW-1:0]    t_reg;
    logic [WORD_W-1:0] sword_reg;
    logic [WIW-1:0]    w_reg;
    logic [ID_W-1:0]   m_id_reg;
    logic              m_exh_reg;

    logic [IDW-1:0]    in_id;
    logic [TIW-1:0]    in_t, top_low;
    logic [WIW-1:0]    in_w;

    logic [TIW+WORD_BW-1:0] tk_wcat;
    logic [WIW-1:0]         tk_w;
    logic [WORD_BW-1:0]     tk_b, tk_sb;
    logic [WORD_W-1:0]      tk_dnew, tk_snew;
    logic [IDW-1:0]         tk_id;

    logic [WIW-1:0]     gv_w;
    logic [WORD_BW-1:0] gv_b, gv_sb;
    logic [WORD_W-1:0]  gv_sword, gv_dword;
    logic               gv_new;
    logic               nf_avail;

    assign in_id = IDW'(s_value);
    assign in_t  = TIW'(in_id >> SPAN_BW);
    assign in_w  = in_id[IDW-1:WORD_BW];

    always_comb begin
        top_low = '0;
        for (int i = NT - 1; i >= 0; i--) begin
            if (top_reg[i]) begin
                top_low = TIW'(i);
            end
        end
    end

    assign sts.top_any = |top_reg;
    assign sts.gb_ok   = (in_id != '0) && (CMPW'(s_value) < CMPW'(next_fresh_reg));

    assign sum_raddr = (s_kind == KIND_GIVE) ? in_t : top_low;

    // take path
    assign tk_wcat = {t_reg, lowest_set(sum_rdata_reg)};
    assign tk_w    = tk_wcat[WIW-1:0];
    assign tk_b    = lowest_set(data_rdata_reg);
    assign tk_sb   = w_reg[WORD_BW-1:0];
    assign tk_dnew = data_rdata_reg & ~(WORD_W'(1) << tk_b);
    assign tk_snew = sword_reg & ~(WORD_W'(1) << tk_sb);
    assign tk_id   = {w_reg, tk_b};

    // give-back path; words not covered by a set bit above them read as zero
    assign gv_w     = value_reg[IDW-1:WORD_BW];
    assign gv_b     = value_reg[WORD_BW-1:0];
    assign gv_sb    = gv_w[WORD_BW-1:0];
    assign gv_sword = top_reg[t_reg] ? sum_rdata_reg : '0;
    assign gv_dword = gv_sword[gv_sb] ? data_rdata_reg : '0;
    assign gv_new   = !gv_dword[gv_b];

    assign nf_avail = (next_fresh_reg <= MAX_NF);

    always_comb begin
        priority if (cmd.tk_sum) begin
            data_raddr = tk_w;
        end else if (cmd.tk_hold) begin
            data_raddr = w_reg;
        end else begin
            data_raddr = in_w;
        end
    end

    always_comb begin
        data_we    = 1'b0;
        data_waddr = w_reg;
        data_wdata = tk_dnew;
        sum_we     = 1'b0;
        sum_waddr  = t_reg;
        sum_wdata  = tk_snew;
        top_next   = top_reg;
        if (cmd.gb_commit && gv_new) begin
            data_we            = 1'b1;
            data_waddr         = gv_w;
            data_wdata         = gv_dword | (WORD_W'(1) << gv_b);
            sum_we             = 1'b1;
            sum_wdata          = gv_sword | (WORD_W'(1) << gv_sb);
            top_next[t_reg]    = 1'b1;
        end else if (cmd.tk_commit) begin
            data_we = 1'b1;
            if (tk_dnew == '0) begin
                sum_we = 1'b1;
                if (tk_snew == '0) begin
                    top_next[t_reg] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_rdata_reg <= data_mem[data_raddr];
        sum_rdata_reg  <= sum_mem[sum_raddr];
        if (data_we) begin
            data_mem[data_waddr] <= data_wdata;
        end
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            value_reg <= in_id;
            t_reg     <= sum_raddr;
        end
        if (cmd.tk_sum) begin
            sword_reg <= sum_rdata_reg;
            w_reg     <= tk_w;
        end
        if (cmd.tk_commit) begin
            m_id_reg  <= tk_id[ID_W-1:0];
            m_exh_reg <= 1'b0;
        end else if (cmd.fresh_commit) begin
            m_id_reg  <= nf_avail ? ID_W'(next_fresh_reg) : '0;
            m_exh_reg <= !nf_avail;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg        <= '0;
            next_fresh_reg <= NFW'(1);
        end else begin
            top_reg <= top_next;
            if (cmd.fresh_commit && nf_avail) begin
                next_fresh_reg <= next_fresh_reg + NFW'(1);
            end
        end
    end

    assign m_id        = m_id_reg;
    assign m_exhausted = m_exh_reg;

endmodule

/* design/smallest_free_id_allocator_core.sv */
// A bitmap take or a fresh take ends by loading the result register. A give-back keeps the
// input busy until written back; an ignored give-back gives no result. Items go one at a
// time through the summary-word read, data-word read and write-back on the bitmap memories;
// a take waits on a full result register, which otherwise frees the input.
// Reset (aresetn, synchronous, active low) sets the counter to 1 and clears the summary
// bits; memory words below a clear summary bit read as zero, so there is no clearing pass.
module smallest_free_id_allocator_core
    import sfid_pkg::*;
#(
    parameter int MAX_ID = MAX_ID_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_kind,
    input  logic [ID_W-1:0] s_value,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [ID_W-1:0] m_id,
    output logic            m_exhausted
);

    // Controller sequences one item at a time; datapath holds all storage.
    sfid_cmd_t cmd;
    sfid_sts_t sts;

    sfid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Two-level bitmap: top summary bits in flops, summary words and data words in
    // memories. A take walks top -> summary word -> data word, then clears bits upward.
    sfid_dp #(
        .MAX_ID (MAX_ID)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_kind      (s_kind),
        .s_value     (s_value),
        .m_id        (m_id),
        .m_exhausted (m_exhausted)
    );

    // A bitmap take only commits while some given-back ID is held.
    a_tk_has_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tk_commit |-> sts.top_any)
        else $error("bitmap take committed with empty bitmap");

    // A fresh take never bypasses a held given-back ID.
    a_fresh_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fresh_commit |-> !sts.top_any)
        else $error("fresh ID handed out while bitmap held IDs");

    // An exhausted result carries ID zero.
    a_exh_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_exhausted) |-> (m_id == '0))
        else $error("exhausted transfer with nonzero ID");

    // Any commit leaves the controller idle for the next transfer.
    a_commit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.tk_commit || cmd.fresh_commit || cmd.gb_commit) |=> s_ready)
        else $error("controller not idle after commit");

endmodule

/* dv/tb_smallest_free_id_allocator_core.sv */
// Testbench for the smallest free ID allocator core: directed and random traffic checked against a predictor.
`timescale 1ns / 1ps

module tb_smallest_free_id_allocator_core;
    import sfid_pkg::*;

    localparam int POOL_MAX    = MAX_ID_DEF;
    localparam int RANDOM_REQS = 560;
    localparam int TAIL_REQS   = 120;   // take-heavy requests after the balanced mix
    localparam int EXHAUST_HIT = 40;    // exhausted grants that end the take-heavy tail early
    localparam int DRAIN_LIMIT = 4000;  // cycles allowed for outstanding grants at the end

    // One grant as the result channel carries it.
    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            exhausted;
    } grant_t;

    // Scoreboard: tracks the free-ID pool and the grants still owed by the block.
    class id_pool_model;
        bit          returned_map [POOL_MAX+1];
        int unsigned next_fresh;
        int unsigned returned_count;
        int unsigned exhausted_seen;
        int unsigned mismatch_count;
        grant_t      pending_grants[$];

        function new();
            foreach (returned_map[i]) returned_map[i] = 1'b0;
            next_fresh     = 1;
            returned_count = 0;
            exhausted_seen = 0;
            mismatch_count = 0;
        endfunction

        // Update the pool for one accepted request; a take owes exactly one grant.
        function void note_request(input logic kind, input logic [ID_W-1:0] value);
            grant_t g;
            int unsigned k;
            if (kind == KIND_GIVE) begin
                // zero, never-issued and duplicate give-backs drop silently
                if (value != 0 && value < next_fresh && !returned_map[value]) begin
                    returned_map[value] = 1'b1;
                    returned_count++;
                end
                return;
            end
            g.exhausted = 1'b0;
            if (returned_count != 0) begin
                for (k = 1; k <= POOL_MAX; k++) begin
                    if (returned_map[k]) break;
                end
                returned_map[k] = 1'b0;
                returned_count--;
                g.id = ID_W'(k);
            end else if (next_fresh <= POOL_MAX) begin
                g.id = ID_W'(next_fresh);
                next_fresh++;
            end else begin
                g.id        = '0;
                g.exhausted = 1'b1;
                exhausted_seen++;
            end
            pending_grants.push_back(g);
        endfunction

        // Compare one grant off the result channel with the oldest one owed.
        function void check_grant(input logic [ID_W-1:0] id, input logic exhausted);
            grant_t g;
            if (pending_grants.size() == 0) begin
                $display("%0t: unexpected grant, expected none, got id %0d exhausted %0b",
                         $time, id, exhausted);
                mismatch_count++;
                return;
            end
            g = pending_grants.pop_front();
            if (id !== g.id) begin
                $display("%0t: grant id mismatch, expected %0d, got %0d", $time, g.id, id);
                mismatch_count++;
            end
            if (exhausted !== g.exhausted) begin
                $display("%0t: exhausted flag mismatch, expected %0b, got %0b",
                         $time, g.exhausted, exhausted);
                mismatch_count++;
            end
        endfunction
    endclass

    logic            aclk        = 1'b0;
    logic            aresetn     = 1'b0;
    logic            s_valid     = 1'b0;
    logic            s_ready;
    logic            s_kind      = KIND_TAKE;
    logic [ID_W-1:0] s_value     = '0;
    logic            m_valid;
    logic            m_ready     = 1'b0;
    logic [ID_W-1:0] m_id;
    logic            m_exhausted;

    id_pool_model pool = new();

    int unsigned     cycle_count = 0;
    bit              send_steady = 1'b0;  // no sender gaps while set
    logic [ID_W-1:0] last_give   = '0;

    always #2 aclk = ~aclk;

    smallest_free_id_allocator_core #(
        .MAX_ID (POOL_MAX)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_id        (m_id),
        .m_exhausted (m_exhausted)
    );

    // Result side: check each grant transfer, then pick the next ready value.
    // A window of cycles keeps ready high throughout to get back-to-back grants.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            pool.check_grant(m_id, m_exhausted);
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (cycle_count >= 2000 && cycle_count < 3500) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 34);
        end
    end

    // Present one request and hold it until the transfer; the pool is
    // updated right at the accepting edge so the next pick sees it.
    task automatic send_request(input logic kind, input logic [ID_W-1:0] value);
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        pool.note_request(kind, value);
        if (kind == KIND_GIVE) last_give = value;
    endtask

    // Random sender gap about a third of the time.
    task automatic sender_gap();
        if (!send_steady && $urandom_range(99) < 34) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(7, 3)) @(posedge aclk);
        end
    endtask

    // Random request: take_pct percent takes; give-backs are mostly IDs
    // issued so far, plus noise over the whole field and repeats.
    task automatic send_random(input int unsigned take_pct);
        int unsigned roll;
        logic [ID_W-1:0] v;
        roll = $urandom_range(99);
        if (roll < take_pct) begin
            send_request(KIND_TAKE, ID_W'($urandom));
        end else begin
            roll = $urandom_range(99);
            if (roll < 80 && pool.next_fresh > 1) begin
                v = ID_W'($urandom_range(pool.next_fresh - 1, 1));
            end else if (roll < 92) begin
                v = ID_W'($urandom);
            end else begin
                v = last_give;
            end
            send_request(KIND_GIVE, v);
        end
        sender_gap();
    endtask

    initial begin
        int unsigned n;
        int unsigned drain;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: fresh takes, every kind of ignored give-back, reuse in
        // ascending order, and fall-back to the counter once the map is empty.
        send_request(KIND_TAKE, '0);             sender_gap();
        send_request(KIND_TAKE, '1);             sender_gap();
        send_request(KIND_TAKE, 10'h155);        sender_gap();
        send_request(KIND_TAKE, 10'h2aa);        sender_gap();
        send_request(KIND_GIVE, '0);             sender_gap();  // zero
        send_request(KIND_GIVE, 10'd5);          sender_gap();  // equal to counter
        send_request(KIND_GIVE, '1);             sender_gap();  // far above counter
        send_request(KIND_GIVE, 10'd3);          sender_gap();
        send_request(KIND_GIVE, 10'd3);          sender_gap();  // duplicate
        send_request(KIND_GIVE, 10'd1);          sender_gap();
        send_request(KIND_TAKE, '0);             sender_gap();  // gets 1
        send_request(KIND_TAKE, '0);             sender_gap();  // gets 3
        send_request(KIND_TAKE, '0);             sender_gap();  // fresh 5
        send_request(KIND_GIVE, 10'd4);          sender_gap();
        send_request(KIND_GIVE, 10'd2);          sender_gap();
        send_request(KIND_GIVE, 10'd5);          sender_gap();
        send_request(KIND_TAKE, '0);             sender_gap();  // gets 2
        send_request(KIND_TAKE, '0);             sender_gap();  // gets 4
        send_request(KIND_TAKE, '0);             sender_gap();  // gets 5
        send_request(KIND_TAKE, '0);             sender_gap();  // fresh 6

        // Balanced random mix; a stretch in the middle runs with no gaps.
        for (n = 0; n < RANDOM_REQS; n++) begin
            send_steady = (n >= 300 && n < 450);
            send_random(55);
        end
        send_steady = 1'b0;

        // Take-heavy tail pushes the counter up; stops early if the pool runs dry.
        n = 0;
        while (pool.exhausted_seen < EXHAUST_HIT && n < TAIL_REQS) begin
            send_random(85);
            n++;
        end

        s_valid <= 1'b0;
        drain = 0;
        while (pool.pending_grants.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        // let any stray grants show up
        repeat (16) @(posedge aclk);

        if (pool.mismatch_count == 0 && pool.pending_grants.size() == 0) begin
            $display("smallest_free_id_allocator_core verification clean");
        end else begin
            $display("smallest_free_id_allocator_core verification failed");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #2_000_000;
        $display("smallest_free_id_allocator_core verification failed");
        $finish;
    end

endmodule
